[sv/vau_pkg.sv]
// shared types and constants of the 3-vector arithmetic unit
package vau_pkg;

    localparam int WORD_W   = 32;
    localparam int SQ_STEPS = 32;   // one root bit per sqrt stage
    localparam int DV_STEPS = 32;   // one quotient bit per divider stage

    typedef logic signed [WORD_W-1:0] t_word;

    // operation codes
    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_SCALE = 3'd2,
        FN_DIV   = 3'd3,
        FN_LEN   = 3'd4,
        FN_NORM  = 3'd5,
        FN_CROSS = 3'd6,
        FN_ABS   = 3'd7
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_ZNORM = 2'd2
    } t_status;

    // operands and partial results that travel down the pipeline
    typedef struct {
        t_func       func;
        t_word       a [3];
        t_word       f;
        t_word       r [3];
        logic [30:0] len;
        t_status     st;
    } t_side;

endpackage

[sv/vec3_arith_unit_top.sv]
// top level of the pipelined 3-vector arithmetic unit
//
//  channel  | dir | handshake             | contents
//  ---------+-----+-----------------------+-----------------------------------
//  slave    | in  | i_s_tvalid/o_s_tready | operation code and operand vectors
//  master   | out | o_m_tvalid/i_m_tready | result vector, length, status
//
// operand select, multiply and rescale come first, then the square root (one
// root bit per stage), then the divider (prepare, one quotient bit per stage,
// sign and saturate); one word is taken every cycle unless the output stalls.
// reset clears every valid bit; the pipeline is empty afterwards.
// the whole pipeline holds while the output word waits, so nothing is lost
// or repeated under stalls.
module vec3_arith_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [223:0] i_s_tdata,   // ax, ay, az, bx, by, bz, factor
    input  logic [2:0]   i_s_tuser,   // func
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata    // rx, ry, rz, length, status, zero pad
);
    import vau_pkg::*;

    logic    w_en;
    t_word   w_a [3], w_b [3], w_f;
    logic    w_mul_vld, w_sq_vld, w_dv_vld;
    t_side   w_mul_side, w_sq_side;
    logic [63:0] w_sum;
    logic [31:0] w_root;
    t_word   w_r [3];
    logic [30:0] w_len;
    t_status w_st;

    // global advance: move when the output slot is free or being taken
    assign w_en       = !w_dv_vld || i_m_tready;
    assign o_s_tready = w_en;

    // unpack the input word
    assign w_a[0] = i_s_tdata[31:0];
    assign w_a[1] = i_s_tdata[63:32];
    assign w_a[2] = i_s_tdata[95:64];
    assign w_b[0] = i_s_tdata[127:96];
    assign w_b[1] = i_s_tdata[159:128];
    assign w_b[2] = i_s_tdata[191:160];
    assign w_f    = i_s_tdata[223:192];

    vau_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_func  (t_func'(i_s_tuser)),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_f     (w_f),
        .o_vld   (w_mul_vld),
        .o_side  (w_mul_side),
        .o_sum   (w_sum)
    );

    vau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mul_vld),
        .i_side  (w_mul_side),
        .i_sum   (w_sum),
        .o_vld   (w_sq_vld),
        .o_side  (w_sq_side),
        .o_root  (w_root)
    );

    vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_side  (w_sq_side),
        .i_root  (w_root),
        .o_vld   (w_dv_vld),
        .o_r     (w_r),
        .o_len   (w_len),
        .o_st    (w_st)
    );

    // pack the output word
    assign o_m_tvalid = w_dv_vld;
    assign o_m_tdata  = {7'd0, w_st, w_len, w_r[2], w_r[1], w_r[0]};

endmodule

[sv/vau_mul.sv]
// operand selection, multipliers, product combine and rescale (four stages)
module vau_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  vau_pkg::t_func i_func,
    input  vau_pkg::t_word i_a [3],
    input  vau_pkg::t_word i_b [3],
    input  vau_pkg::t_word i_f,
    output logic          o_vld,
    output vau_pkg::t_side o_side,
    output logic [63:0]   o_sum
);
    import vau_pkg::*;

    localparam logic [64:0]        RND   = 65'd1 << (FRAC_BITS - 1);
    localparam logic signed [64:0] W_MAX = 65'sh0_7fff_ffff;
    localparam logic signed [64:0] W_MIN = -W_MAX - 65'sd1;

    // saturate a 33-bit sum to one word
    function automatic t_word sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    t_side n_side1, r_side1, r_side2, r_side3, n_side4, r_side4;
    t_word n_m0a [3], n_m0b [3], n_m1a [3], n_m1b [3];
    t_word r_m0a [3], r_m0b [3], r_m1a [3], r_m1b [3];
    logic signed [63:0] r_p0 [3], r_p1 [3];
    logic signed [64:0] r_w [3];
    logic signed [64:0] w_sh [3];
    logic [63:0] r_sum;
    logic r_vld1, r_vld2, r_vld3, r_vld4;

    // stage 1: simple results and multiplier operands
    always_comb begin
        int j, k;
        n_side1.func = i_func;
        n_side1.a    = i_a;
        n_side1.f    = i_f;
        n_side1.len  = '0;
        n_side1.st   = ST_OK;
        for (int i = 0; i < 3; i++) begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            n_side1.r[i] = '0;
            n_m0a[i] = i_a[i];
            n_m0b[i] = i_a[i];
            n_m1a[i] = '0;
            n_m1b[i] = '0;
            case (i_func)
                FN_ADD: n_side1.r[i] = sat33({i_a[i][31], i_a[i]} + {i_b[i][31], i_b[i]});
                FN_SUB: n_side1.r[i] = sat33({i_a[i][31], i_a[i]} - {i_b[i][31], i_b[i]});
                FN_ABS: n_side1.r[i] = sat33(i_a[i][31] ? -{i_a[i][31], i_a[i]}
                                                       : {i_a[i][31], i_a[i]});
                FN_SCALE: n_m0b[i] = i_f;
                FN_CROSS: begin
                    n_m0a[i] = i_a[j];
                    n_m0b[i] = i_b[k];
                    n_m1a[i] = i_a[k];
                    n_m1b[i] = i_b[j];
                end
                default: ;
            endcase
        end
    end

    // stage 4: shift and saturate the rounded products of scale and cross
    always_comb begin
        n_side4 = r_side3;
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = r_w[i] >>> FRAC_BITS;
            if (r_side3.func == FN_SCALE || r_side3.func == FN_CROSS) begin
                if (w_sh[i] > W_MAX) begin
                    n_side4.r[i] = 32'sh7fff_ffff;
                end else if (w_sh[i] < W_MIN) begin
                    n_side4.r[i] = 32'sh8000_0000;
                end else begin
                    n_side4.r[i] = w_sh[i][31:0];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side1;
            r_m0a   <= n_m0a;
            r_m0b   <= n_m0b;
            r_m1a   <= n_m1a;
            r_m1b   <= n_m1b;
            r_side2 <= r_side1;
            for (int i = 0; i < 3; i++) begin
                r_p0[i] <= r_m0a[i] * r_m0b[i];
                r_p1[i] <= r_m1a[i] * r_m1b[i];
                r_w[i]  <= {r_p0[i][63], r_p0[i]} - {r_p1[i][63], r_p1[i]} + RND;
            end
            r_side3 <= r_side2;
            r_sum   <= $unsigned(r_p0[0]) + $unsigned(r_p0[1]) + $unsigned(r_p0[2]);
            r_side4 <= n_side4;
            o_sum   <= r_sum;
        end
    end

    assign o_vld  = r_vld4;
    assign o_side = r_side4;

endmodule

[sv/vau_sqrt.sv]
// pipelined integer square root, one root bit per stage
module vau_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  vau_pkg::t_side i_side,
    input  logic [63:0]   i_sum,
    output logic          o_vld,
    output vau_pkg::t_side o_side,
    output logic [31:0]   o_root
);
    import vau_pkg::*;

    logic [63:0] r_x    [SQ_STEPS];
    logic [33:0] r_rem  [SQ_STEPS];
    logic [31:0] r_root [SQ_STEPS];
    logic        r_vld  [SQ_STEPS];
    t_side       r_side [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic [63:0] w_x;
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic        w_vld;
        t_side       w_side;
        logic [35:0] w_cur, w_trial, w_diff;

        if (k == 0) begin : g_first
            assign w_x    = i_sum;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_vld  = i_vld;
            assign w_side = i_side;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
        end

        // bring down two bits and try the next root bit
        assign w_cur   = {w_rem, w_x[63:62]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {w_x[61:0], 2'b00};
                r_side[k] <= w_side;
                if (w_cur >= w_trial) begin
                    r_rem[k]  <= w_diff[33:0];
                    r_root[k] <= {w_root[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur[33:0];
                    r_root[k] <= {w_root[30:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];
    assign o_root = r_root[SQ_STEPS-1];

endmodule

[sv/vau_div.sv]
// pipelined fixed-point divider for divide and normalize, three lanes
module vau_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  vau_pkg::t_side i_side,
    input  logic [31:0]   i_root,
    output logic          o_vld,
    output vau_pkg::t_word o_r [3],
    output logic [30:0]   o_len,
    output vau_pkg::t_status o_st
);
    import vau_pkg::*;

    // preparation stage
    logic [31:0] w_absa [3];
    logic [31:0] w_absf, w_d, w_hi;
    t_side       n_p_side, r_p_side;
    logic [2:0][31:0] n_p_rem, n_p_lo, r_p_rem, r_p_lo;
    logic [2:0]  n_p_ovf, n_p_neg, r_p_ovf, r_p_neg;
    logic [31:0] r_p_d;
    logic        r_p_vld;

    // quotient stages
    logic [2:0][31:0] r_rem [DV_STEPS];
    logic [2:0][31:0] r_lo  [DV_STEPS];
    logic [2:0][31:0] r_q   [DV_STEPS];
    logic [31:0]      r_d   [DV_STEPS];
    logic [2:0]       r_ovf [DV_STEPS];
    logic [2:0]       r_neg [DV_STEPS];
    t_side            r_side[DV_STEPS];
    logic             r_vld [DV_STEPS];

    // output stage
    t_word   n_o_r [3];
    t_word   r_o_r [3];
    logic [31:0] w_q;
    logic [30:0] r_o_len;
    t_status r_o_st;
    logic    r_o_vld;
    t_side   w_last;

    // magnitudes, divisor, length, overflow test and status
    always_comb begin
        w_absf = i_side.f[31] ? (~i_side.f + 32'd1) : i_side.f;
        w_d    = (i_side.func == FN_NORM) ? i_root : w_absf;
        n_p_side = i_side;
        n_p_side.len = '0;
        n_p_side.st  = ST_OK;
        w_hi = '0;
        if (i_side.func == FN_LEN) begin
            n_p_side.len = i_root[31] ? 31'h7fff_ffff : i_root[30:0];
        end
        if (i_side.func == FN_DIV && i_side.f == '0) begin
            n_p_side.st = ST_DIV0;
        end
        if (i_side.func == FN_NORM && i_root == '0) begin
            n_p_side.st = ST_ZNORM;
        end
        for (int i = 0; i < 3; i++) begin
            w_absa[i]  = i_side.a[i][31] ? (~i_side.a[i] + 32'd1) : i_side.a[i];
            w_hi       = w_absa[i] >> (32 - FRAC_BITS);
            n_p_rem[i] = w_hi;
            n_p_lo[i]  = w_absa[i] << FRAC_BITS;
            n_p_ovf[i] = (w_hi >= w_d);
            n_p_neg[i] = i_side.a[i][31] ^ ((i_side.func == FN_DIV) & i_side.f[31]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_side <= n_p_side;
            r_p_rem  <= n_p_rem;
            r_p_lo   <= n_p_lo;
            r_p_ovf  <= n_p_ovf;
            r_p_neg  <= n_p_neg;
            r_p_d    <= w_d;
        end
    end

    for (genvar k = 0; k < DV_STEPS; k++) begin : g_stage
        logic [2:0][31:0] w_rem, w_lo, w_q_in;
        logic [31:0] w_dk;
        logic [2:0]  w_ovf, w_neg;
        t_side       w_side;
        logic        w_vld;
        logic [32:0] w_cur [3];
        logic [32:0] w_sub [3];

        if (k == 0) begin : g_first
            assign w_rem  = r_p_rem;
            assign w_lo   = r_p_lo;
            assign w_q_in = '0;
            assign w_dk   = r_p_d;
            assign w_ovf  = r_p_ovf;
            assign w_neg  = r_p_neg;
            assign w_side = r_p_side;
            assign w_vld  = r_p_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_lo   = r_lo[k-1];
            assign w_q_in = r_q[k-1];
            assign w_dk   = r_d[k-1];
            assign w_ovf  = r_ovf[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        // shift in the next numerator bit and subtract where it fits
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_cur[i] = {w_rem[i], w_lo[i][31]};
                w_sub[i] = w_cur[i] - {1'b0, w_dk};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k]    <= w_dk;
                r_ovf[k]  <= w_ovf;
                r_neg[k]  <= w_neg;
                r_side[k] <= w_side;
                for (int i = 0; i < 3; i++) begin
                    r_lo[k][i] <= {w_lo[i][30:0], 1'b0};
                    if (w_cur[i] >= {1'b0, w_dk}) begin
                        r_rem[k][i] <= w_sub[i][31:0];
                        r_q[k][i]   <= {w_q_in[i][30:0], 1'b1};
                    end else begin
                        r_rem[k][i] <= w_cur[i][31:0];
                        r_q[k][i]   <= {w_q_in[i][30:0], 1'b0};
                    end
                end
            end
        end
    end

    assign w_last = r_side[DV_STEPS-1];

    // sign, saturation and result selection
    always_comb begin
        w_q = '0;
        for (int i = 0; i < 3; i++) begin
            n_o_r[i] = w_last.r[i];
            if (w_last.func == FN_DIV || w_last.func == FN_NORM) begin
                w_q = r_q[DV_STEPS-1][i];
                if (w_last.st != ST_OK) begin
                    n_o_r[i] = '0;
                end else if (r_ovf[DV_STEPS-1][i]) begin
                    n_o_r[i] = r_neg[DV_STEPS-1][i] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else if (r_neg[DV_STEPS-1][i]) begin
                    n_o_r[i] = (w_q > 32'h8000_0000) ? 32'sh8000_0000 : -w_q;
                end else begin
                    n_o_r[i] = w_q[31] ? 32'sh7fff_ffff : w_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[DV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_r   <= n_o_r;
            r_o_len <= w_last.len;
            r_o_st  <= w_last.st;
        end
    end

    assign o_vld = r_o_vld;
    assign o_r   = r_o_r;
    assign o_len = r_o_len;
    assign o_st  = r_o_st;

endmodule
